[design/gphsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gphsr_pkg: shared types and constants for the gamepad hold-state report builder
// Item and report layouts, function codes, button remap and d-pad tables.
// ----------------------------------------------------------------------------
package gphsr_pkg;

    localparam int STATE_BITS   = 21;   // buttons kept in state
    localparam int WIRE_BITS    = 26;   // buttons on the wire
    localparam int STICK_BITS   = 8;
    localparam int PACKED_BITS  = 24;
    localparam int TIME_BITS    = 32;
    localparam int HOLD_BITS    = 16;
    localparam int INTERVAL_BITS = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam int BUTTON_COUNT = 21;
    localparam logic [4:0] BTN_LIMIT =
        5'((BUTTON_COUNT < STATE_BITS) ? BUTTON_COUNT : STATE_BITS);

    localparam logic [STATE_BITS-1:0] STATE_MASK = 21'h1F_FFFF;
    localparam logic [STATE_BITS-1:0] DPAD_MASK  = 21'h00_0F00;
    localparam logic [STICK_BITS-1:0] STICK_CENTER = 8'h80;

    localparam int IN_DATA_BITS  = 96;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 88;

    typedef enum logic [2:0] {
        FUNC_PRESS     = 3'd0,
        FUNC_RELEASE   = 3'd1,
        FUNC_DPAD      = 3'd2,
        FUNC_SET_STATE = 3'd3,
        FUNC_TICK      = 3'd4
    } func_t;

    typedef enum logic {
        CFG_MIN_HOLD        = 1'b0,
        CFG_REPORT_INTERVAL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        func_t                  func;
        logic [4:0]             button_index;
        logic [3:0]             dpad_dir;
        logic [STATE_BITS-1:0]  all_buttons;
        logic [STICK_BITS-1:0]  left_x;
        logic [STICK_BITS-1:0]  left_y;
        logic [STICK_BITS-1:0]  right_x;
        logic [STICK_BITS-1:0]  right_y;
        logic [TIME_BITS-1:0]   now_ms;
        logic                   link_up;
    } in_item_t;

    typedef struct packed {
        logic [7:0]             counter;
        logic [STATE_BITS-1:0]  buttons;
        logic [STICK_BITS-1:0]  left_x;
        logic [STICK_BITS-1:0]  left_y;
        logic [STICK_BITS-1:0]  right_x;
        logic [STICK_BITS-1:0]  right_y;
    } report_t;

    // Wire bit for each internal button bit.
    localparam logic [4:0] WIRE_POS [STATE_BITS] = '{
        5'd2,  5'd3,  5'd0,  5'd1,  5'd6,  5'd7,  5'd9,  5'd10, 5'd16, 5'd18, 5'd19,
        5'd17, 5'd22, 5'd23, 5'd8,  5'd11, 5'd12, 5'd13, 5'd24, 5'd25, 5'd14
    };

    function automatic logic [WIRE_BITS-1:0] remap_to_wire(input logic [STATE_BITS-1:0] b);
        logic [WIRE_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < STATE_BITS; i++) begin
            if (b[i]) begin
                w[WIRE_POS[i]] = 1'b1;
            end
        end
        return w;
    endfunction

    // D-pad nibble: bit 0 down, bit 1 right, bit 2 left, bit 3 up.
    function automatic logic [3:0] dpad_bits(input logic [2:0] dir);
        logic [3:0] r;
        case (dir)
            3'd0:    r = 4'b1000;
            3'd1:    r = 4'b1010;
            3'd2:    r = 4'b0010;
            3'd3:    r = 4'b0011;
            3'd4:    r = 4'b0001;
            3'd5:    r = 4'b0101;
            3'd6:    r = 4'b0100;
            3'd7:    r = 4'b1100;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

    // 12-bit X in the low bits, 12-bit Y above, each value shifted left by 4.
    function automatic logic [PACKED_BITS-1:0] pack_stick(input logic [STICK_BITS-1:0] x,
                                                          input logic [STICK_BITS-1:0] y);
        return {y, 4'h0, x, 4'h0};
    endfunction

endpackage
`default_nettype wire

[design/gphsr_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gphsr_in_stage: input register
// Holds one accepted item until the state stage consumes it.
// ----------------------------------------------------------------------------
module gphsr_in_stage
    import gphsr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          item_valid,
    output in_item_t      item,
    input  wire logic     advance
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[design/gphsr_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gphsr_state: controller state and event handling
// Applies one item per cycle to the button, stick and timing state; a reporting item waits for room.
// ----------------------------------------------------------------------------
module gphsr_state
    import gphsr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  wire logic                     item_valid,
    input  wire in_item_t                 item,
    input  wire logic                     out_free,
    output logic                          advance,
    output logic                          emit,
    output report_t                       report
);

    logic [HOLD_BITS-1:0]     min_hold_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [STATE_BITS-1:0]    held_reg, held_next;
    logic [STATE_BITS-1:0]    deferred_reg, deferred_next;
    logic [TIME_BITS-1:0]     last_press_reg, last_press_next;
    logic [TIME_BITS-1:0]     last_report_reg, last_report_next;
    logic [7:0]               seq_reg, seq_next;
    logic [STICK_BITS-1:0]    stick_reg [4];
    logic [STICK_BITS-1:0]    stick_next [4];

    logic [TIME_BITS-1:0]  press_age;
    logic [TIME_BITS-1:0]  report_age;
    logic                  hold_not_met;
    logic                  interval_met;
    logic                  btn_ok;
    logic [STATE_BITS-1:0] btn_mask;
    logic                  emit_c;

    always_comb begin
        press_age    = item.now_ms - last_press_reg;
        report_age   = item.now_ms - last_report_reg;
        hold_not_met = press_age < {{(TIME_BITS-HOLD_BITS){1'b0}}, min_hold_reg};
        interval_met = !(report_age < {{(TIME_BITS-INTERVAL_BITS){1'b0}}, interval_reg});
        btn_ok       = item.button_index < BTN_LIMIT;
        btn_mask     = btn_ok ? (STATE_BITS'(1) << item.button_index) : '0;

        held_next        = held_reg;
        deferred_next    = deferred_reg;
        last_press_next  = last_press_reg;
        last_report_next = last_report_reg;
        stick_next       = stick_reg;
        emit_c           = 1'b0;

        case (item.func)
            FUNC_PRESS: begin
                if (btn_ok) begin
                    held_next       = (held_reg | btn_mask) & STATE_MASK;
                    deferred_next   = deferred_reg & ~btn_mask;
                    last_press_next = item.now_ms;
                end
            end
            FUNC_RELEASE: begin
                if (btn_ok) begin
                    if (hold_not_met) begin
                        deferred_next = (deferred_reg | btn_mask) & STATE_MASK;
                    end else begin
                        held_next     = held_reg & ~btn_mask;
                        deferred_next = deferred_reg & ~btn_mask;
                    end
                end
            end
            FUNC_DPAD: begin
                if (!item.dpad_dir[3]) begin
                    held_next = (held_reg & ~DPAD_MASK)
                              | {9'b0, dpad_bits(item.dpad_dir[2:0]), 8'b0};
                    deferred_next   = deferred_reg & ~DPAD_MASK;
                    last_press_next = item.now_ms;
                end else if (hold_not_met) begin
                    // neutral too soon: defer the held d-pad bits
                    deferred_next = deferred_reg | (held_reg & DPAD_MASK);
                end else begin
                    held_next     = held_reg & ~DPAD_MASK;
                    deferred_next = deferred_reg & ~DPAD_MASK;
                end
            end
            FUNC_SET_STATE: begin
                held_next     = item.all_buttons & STATE_MASK;
                deferred_next = '0;
                stick_next[0] = item.left_x;
                stick_next[1] = item.left_y;
                stick_next[2] = item.right_x;
                stick_next[3] = item.right_y;
                emit_c        = item.link_up;
            end
            FUNC_TICK: begin
                if (item.link_up) begin
                    if ((deferred_reg != '0) && !hold_not_met) begin
                        held_next     = held_reg & ~deferred_reg;
                        deferred_next = '0;
                    end
                    if (interval_met) begin
                        last_report_next = item.now_ms;
                        emit_c           = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        seq_next = emit_c ? seq_reg + 8'd1 : seq_reg;
    end

    // An item that reports waits for room in the result register.
    assign emit    = item_valid && emit_c;
    assign advance = item_valid && (!emit_c || out_free);

    assign report.counter = seq_reg;
    assign report.buttons = held_next;
    assign report.left_x  = stick_next[0];
    assign report.left_y  = stick_next[1];
    assign report.right_x = stick_next[2];
    assign report.right_y = stick_next[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hold_reg    <= HOLD_BITS'(50);
            interval_reg    <= INTERVAL_BITS'(8);
            held_reg        <= '0;
            deferred_reg    <= '0;
            last_press_reg  <= '0;
            last_report_reg <= '0;
            seq_reg         <= '0;
            for (int i = 0; i < 4; i++) begin
                stick_reg[i] <= STICK_CENTER;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_MIN_HOLD:        min_hold_reg <= cfg_wr_data;
                    CFG_REPORT_INTERVAL: interval_reg <= cfg_wr_data[INTERVAL_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (advance) begin
                held_reg        <= held_next;
                deferred_reg    <= deferred_next;
                last_press_reg  <= last_press_next;
                last_report_reg <= last_report_next;
                seq_reg         <= seq_next;
                stick_reg       <= stick_next;
            end
        end
    end

    // Sequence count moves by one exactly with each delivered report.
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (seq_reg == $past(seq_reg) + 8'd1))
        else $error("sequence count did not step on report");

    a_seq_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && emit) |=> $stable(seq_reg))
        else $error("sequence count moved without report");

    // Only a reporting tick moves the periodic report time.
    a_report_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && emit && (item.func == FUNC_TICK)) |=> $stable(last_report_reg))
        else $error("report time moved without a tick report");

    // A full-state set leaves nothing deferred.
    a_set_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (item.func == FUNC_SET_STATE)) |=> (deferred_reg == '0))
        else $error("deferred releases survived a full-state set");

endmodule
`default_nettype wire

[design/gphsr_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gphsr_out_stage: result register
// Remaps buttons to wire order, packs sticks, and holds the report.
// ----------------------------------------------------------------------------
module gphsr_out_stage
    import gphsr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire report_t                report,
    output logic                        out_free,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  report_counter,
    output logic [WIRE_BITS-1:0]        wire_buttons,
    output logic [PACKED_BITS-1:0]      left_stick_packed,
    output logic [PACKED_BITS-1:0]      right_stick_packed
);

    logic                   valid_reg;
    logic [7:0]             counter_reg;
    logic [WIRE_BITS-1:0]   wire_reg;
    logic [PACKED_BITS-1:0] left_reg;
    logic [PACKED_BITS-1:0] right_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            counter_reg <= report.counter;
            wire_reg    <= remap_to_wire(report.buttons);
            left_reg    <= pack_stick(report.left_x, report.left_y);
            right_reg   <= pack_stick(report.right_x, report.right_y);
        end
    end

    assign m_valid            = valid_reg;
    assign report_counter     = counter_reg;
    assign wire_buttons       = wire_reg;
    assign left_stick_packed  = left_reg;
    assign right_stick_packed = right_reg;

endmodule
`default_nettype wire

[design/gamepad_hold_state_report_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_hold_state_report_builder: gamepad state keeper and report source
// Tracks buttons and sticks, defers early releases, emits controller reports.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle: press, release, d-pad, full-state
// set or tick (tuser carries the function code). Each transfer lands in an
// input register, is applied to the button, stick and timing state by one pass
// of logic, and any report it causes is written into a result register, which
// presents it on the master side. The sustained rate is one item per cycle; an
// item that reports waits in the input register only while the result register
// holds a report that is not being taken, and items that report nothing pass by
// a full result register. Ticks and full-state sets report only with link_up
// high. Write min_hold_ms and report_interval_ms only while no transfer is in
// flight.
// ----------------------------------------------------------------------------
module gamepad_hold_state_report_builder
    import gphsr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration writes: index 0 min_hold_ms, index 1 report_interval_ms
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    // event input
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // low to high: button_index[4:0], dpad_dir[8:5], all_buttons[29:9],
    // left_x[37:30], left_y[45:38], right_x[53:46], right_y[61:54],
    // now_ms[93:62], link_up[94], zero[95]
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // func[2:0]
    input  wire logic [IN_USER_BITS-1:0]  s_tuser,
    // report output
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // low to high: report_counter[7:0], wire_buttons[33:8],
    // left_stick_packed[57:34], right_stick_packed[81:58], zero[87:82]
    output logic [OUT_DATA_BITS-1:0]      m_tdata
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     emit;
    logic     out_free;
    report_t  report;

    logic [7:0]             report_counter;
    logic [WIRE_BITS-1:0]   wire_buttons;
    logic [PACKED_BITS-1:0] left_stick_packed;
    logic [PACKED_BITS-1:0] right_stick_packed;

    // Unpack the transfer into the item fields.
    always_comb begin
        s_item.func         = func_t'(s_tuser);
        s_item.button_index = s_tdata[4:0];
        s_item.dpad_dir     = s_tdata[8:5];
        s_item.all_buttons  = s_tdata[29:9];
        s_item.left_x       = s_tdata[37:30];
        s_item.left_y       = s_tdata[45:38];
        s_item.right_x      = s_tdata[53:46];
        s_item.right_y      = s_tdata[61:54];
        s_item.now_ms       = s_tdata[93:62];
        s_item.link_up      = s_tdata[94];
    end

    // Hold the accepted item until the state logic takes it.
    gphsr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    // Apply the item to the controller state and decide on a report.
    gphsr_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .advance     (advance),
        .emit        (emit),
        .report      (report)
    );

    // Format and hold the report until the master side takes it.
    gphsr_out_stage u_out_stage (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load               (advance && emit),
        .report             (report),
        .out_free           (out_free),
        .m_valid            (m_tvalid),
        .m_ready            (m_tready),
        .report_counter     (report_counter),
        .wire_buttons       (wire_buttons),
        .left_stick_packed  (left_stick_packed),
        .right_stick_packed (right_stick_packed)
    );

    assign m_tdata = {6'b0, right_stick_packed, left_stick_packed,
                      wire_buttons, report_counter};

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: gamepad hold-state report builder
// Walks a directed event table, then three random phases with different hold
// and interval settings and different idling on each side. Every report is
// compared field by field with a typed report or a button and stick predictor.
// ----------------------------------------------------------------------------
module testbench;
    import gphsr_pkg::*;

    // Function codes the block has no operation for.
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam int DIRECTED_ROWS    = 26;
    localparam int RANDOM_PER_PHASE = 225;
    // Idle time after the last report is taken, before touching registers.
    localparam int SETTLE_CYCLES    = 8;

    // Wire bit that each internal button lands on.
    localparam int WIRE_SLOT [0:STATE_BITS-1] = '{
        2, 3, 0, 1, 6, 7, 9, 10, 16, 18, 19, 17, 22, 23, 8, 11, 12, 13, 24, 25, 14
    };

    // D-pad nibble per direction, up and clockwise: bit 0 down, 1 right, 2 left, 3 up.
    localparam logic [3:0] DPAD_NIBBLE [0:7] = '{
        4'b1000, 4'b1010, 4'b0010, 4'b0011, 4'b0001, 4'b0101, 4'b0100, 4'b1100
    };

    typedef struct packed {
        logic [7:0]             seq;
        logic [WIRE_BITS-1:0]   wire_btn;
        logic [PACKED_BITS-1:0] left_pk;
        logic [PACKED_BITS-1:0] right_pk;
    } pad_report_t;

    typedef struct packed {
        in_item_t    ev;
        logic        typed;     // report below is written out by hand
        pad_report_t rep;
    } directed_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic                     cfg_index = CFG_MIN_HOLD;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [IN_USER_BITS-1:0]  s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    // Predicted block state and register copies.
    logic [STATE_BITS-1:0]    pad_held;
    logic [STATE_BITS-1:0]    pad_deferred;
    logic [TIME_BITS-1:0]     press_stamp;
    logic [TIME_BITS-1:0]     report_stamp;
    logic [7:0]               report_seq;
    logic [STICK_BITS-1:0]    stick_pos [0:3];
    logic [HOLD_BITS-1:0]     hold_limit;
    logic [INTERVAL_BITS-1:0] report_gap;

    pad_report_t   pending_reports [$];
    directed_row_t directed_rows [0:DIRECTED_ROWS-1];
    logic [TIME_BITS-1:0] clock_ms;
    int mismatch_count = 0;
    int sender_idle_pct = 8;
    int receiver_idle_pct = 45;

    gamepad_hold_state_report_builder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_pad();
        pad_held     = '0;
        pad_deferred = '0;
        press_stamp  = '0;
        report_stamp = '0;
        report_seq   = '0;
        for (int i = 0; i < 4; i++) begin
            stick_pos[i] = 8'h80;
        end
        hold_limit = 16'd50;
        report_gap = 8'd8;
    endtask

    function automatic logic [WIRE_BITS-1:0] wire_order(input logic [STATE_BITS-1:0] b);
        logic [WIRE_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < STATE_BITS; i++) begin
            if (b[i]) begin
                w[WIRE_SLOT[i]] = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic logic [PACKED_BITS-1:0] stick_pair(input logic [STICK_BITS-1:0] x,
                                                          input logic [STICK_BITS-1:0] y);
        return {y, 4'h0, x, 4'h0};
    endfunction

    // Wrapping difference against the last press, compared with the hold time.
    function automatic logic hold_short(input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] elapsed;
        elapsed = now - press_stamp;
        return elapsed < TIME_BITS'(hold_limit);
    endfunction

    // Apply one event to the predicted state; return 1 when it causes a report.
    function automatic logic apply_event(input in_item_t it, output pad_report_t rep);
        logic [STATE_BITS-1:0] bit_mask;
        logic [TIME_BITS-1:0]  since_report;
        logic                  emit;
        emit     = 1'b0;
        rep      = '0;
        bit_mask = '0;
        if (it.button_index < BUTTON_COUNT) begin
            bit_mask[it.button_index] = 1'b1;
        end
        case (it.func)
            FUNC_PRESS: if (bit_mask != '0) begin
                pad_held     = pad_held | bit_mask;
                pad_deferred = pad_deferred & ~bit_mask;
                press_stamp  = it.now_ms;
            end
            FUNC_RELEASE: if (bit_mask != '0) begin
                // early release: park it until a tick finds the hold time met
                if (hold_short(it.now_ms)) begin
                    pad_deferred = pad_deferred | bit_mask;
                end else begin
                    pad_held     = pad_held & ~bit_mask;
                    pad_deferred = pad_deferred & ~bit_mask;
                end
            end
            FUNC_DPAD: if (!it.dpad_dir[3]) begin
                pad_held = (pad_held & ~DPAD_MASK) |
                           {9'b0, DPAD_NIBBLE[it.dpad_dir[2:0]], 8'b0};
                pad_deferred = pad_deferred & ~DPAD_MASK;
                press_stamp  = it.now_ms;
            end else if (hold_short(it.now_ms)) begin
                pad_deferred = pad_deferred | (pad_held & DPAD_MASK);
            end else begin
                pad_held     = pad_held & ~DPAD_MASK;
                pad_deferred = pad_deferred & ~DPAD_MASK;
            end
            FUNC_SET_STATE: begin
                pad_held     = it.all_buttons;
                stick_pos[0] = it.left_x;
                stick_pos[1] = it.left_y;
                stick_pos[2] = it.right_x;
                stick_pos[3] = it.right_y;
                pad_deferred = '0;
                emit         = it.link_up;
            end
            FUNC_TICK: if (it.link_up) begin
                if (pad_deferred != '0 && !hold_short(it.now_ms)) begin
                    pad_held     = pad_held & ~pad_deferred;
                    pad_deferred = '0;
                end
                since_report = it.now_ms - report_stamp;
                if (since_report >= TIME_BITS'(report_gap)) begin
                    report_stamp = it.now_ms;
                    emit         = 1'b1;
                end
            end
            default: ;
        endcase
        if (emit) begin
            rep.seq      = report_seq;
            rep.wire_btn = wire_order(pad_held);
            rep.left_pk  = stick_pair(stick_pos[0], stick_pos[1]);
            rep.right_pk = stick_pair(stick_pos[2], stick_pos[3]);
            report_seq   = report_seq + 8'd1;
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Sticks come packed as {right_y, right_x, left_y, left_x}.
    function automatic in_item_t ev(input func_t f, input logic [4:0] idx,
                                    input logic [3:0] dir, input logic [STATE_BITS-1:0] bits,
                                    input logic [31:0] sticks, input logic [TIME_BITS-1:0] now,
                                    input logic link);
        in_item_t it;
        it.func         = f;
        it.button_index = idx;
        it.dpad_dir     = dir;
        it.all_buttons  = bits;
        it.left_x       = sticks[7:0];
        it.left_y       = sticks[15:8];
        it.right_x      = sticks[23:16];
        it.right_y      = sticks[31:24];
        it.now_ms       = now;
        it.link_up      = link;
        return it;
    endfunction

    function automatic directed_row_t plain(input in_item_t e);
        return {e, 1'b0, {$bits(pad_report_t){1'b0}}};
    endfunction

    function automatic directed_row_t known(input in_item_t e, input pad_report_t r);
        return {e, 1'b1, r};
    endfunction

    // Advance the millisecond clock (mostly small steps, sometimes a jump of up
    // to 300, rarely anywhere) and draw one event around it.
    function automatic in_item_t random_event();
        in_item_t it;
        int pick;
        int step;
        pick = $urandom_range(0, 99);
        step = $urandom_range(0, 99);
        if (step < 1) begin
            clock_ms = $urandom();
        end else if (step < 6) begin
            clock_ms = clock_ms + $urandom_range(0, 300);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 12);
        end
        if (pick < 25) begin
            it.func = FUNC_PRESS;
        end else if (pick < 48) begin
            it.func = FUNC_RELEASE;
        end else if (pick < 63) begin
            it.func = FUNC_DPAD;
        end else if (pick < 73) begin
            it.func = FUNC_SET_STATE;
        end else if (pick < 97) begin
            it.func = FUNC_TICK;
        end else begin
            it.func = func_t'(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)));
        end
        if ($urandom_range(0, 9) == 0) begin
            it.button_index = 5'($urandom_range(BUTTON_COUNT, 31));
        end else begin
            it.button_index = 5'($urandom_range(0, BUTTON_COUNT - 1));
        end
        it.dpad_dir    = 4'($urandom_range(0, 15));
        it.all_buttons = STATE_BITS'($urandom());
        it.left_x      = 8'($urandom());
        it.left_y      = 8'($urandom());
        it.right_x     = 8'($urandom());
        it.right_y     = 8'($urandom());
        it.now_ms      = clock_ms;
        it.link_up     = ($urandom_range(0, 99) < 88);
        return it;
    endfunction

    // Hold the event on the slave side until it transfers. Valid stays high
    // between back-to-back events; the sender may idle before each one.
    task automatic send_event(input in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.link_up, it.now_ms, it.right_y, it.right_x, it.left_y,
                     it.left_x, it.all_buttons, it.dpad_dir, it.button_index};
        s_tuser  <= it.func;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Send, then queue the typed report or the predicted one.
    task automatic run_event(input in_item_t it, input logic typed, input pad_report_t typed_rep);
        pad_report_t rep;
        logic        got_one;
        send_event(it);
        got_one = apply_event(it, rep);
        if (typed) begin
            pending_reports.push_back(typed_rep);
        end else if (got_one) begin
            pending_reports.push_back(rep);
        end
    endtask

    task automatic write_reg(input cfg_index_t which, input logic [CFG_DATA_BITS-1:0] value);
        cfg_index   <= which;
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (which == CFG_MIN_HOLD) begin
            hold_limit = value;
        end else begin
            report_gap = value[INTERVAL_BITS-1:0];
        end
    endtask

    // Drop valid, wait for every queued report, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int send_idle, input int recv_idle,
                             input logic [HOLD_BITS-1:0] hold,
                             input logic [INTERVAL_BITS-1:0] gap);
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        write_reg(CFG_MIN_HOLD, hold);
        // upper byte of the interval write carries noise the block must drop
        write_reg(CFG_REPORT_INTERVAL, {8'($urandom()), gap});
        clock_ms = $urandom();
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            run_event(random_event(), 1'b0, '0);
        end
        wait_drained();
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Report side: random stalls, and check every transfer in order.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : report_watch
        pad_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("report with none pending", m_tdata[31:0], '0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[7:0] !== want.seq) begin
                    flag_mismatch("report_counter", 32'(m_tdata[7:0]), 32'(want.seq));
                end
                if (m_tdata[33:8] !== want.wire_btn) begin
                    flag_mismatch("wire_buttons", 32'(m_tdata[33:8]), 32'(want.wire_btn));
                end
                if (m_tdata[57:34] !== want.left_pk) begin
                    flag_mismatch("left_stick_packed", 32'(m_tdata[57:34]),
                                  32'(want.left_pk));
                end
                if (m_tdata[81:58] !== want.right_pk) begin
                    flag_mismatch("right_stick_packed", 32'(m_tdata[81:58]),
                                  32'(want.right_pk));
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        // Directed part runs on the reset register values: hold 50, interval 8.
        directed_rows = '{
            // after reset: first tick at the interval reports the centered pad
            known(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'd8, 1'b1),
                  {8'd0, 26'h0, 24'h800800, 24'h800800}),
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'd10, 1'b1)),   // interval not met
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'd100, 1'b0)),  // link down
            plain(ev(FUNC_PRESS, 5'd0, 4'd0, 21'h0, 32'h0, 32'd100, 1'b0)),
            plain(ev(FUNC_PRESS, 5'd20, 4'd0, 21'h0, 32'h0, 32'd101, 1'b0)),
            plain(ev(FUNC_PRESS, 5'd21, 4'd0, 21'h0, 32'h0, 32'd102, 1'b1)), // out of range
            plain(ev(FUNC_PRESS, 5'd31, 4'd0, 21'h0, 32'h0, 32'd103, 1'b1)),
            plain(ev(FUNC_RELEASE, 5'd0, 4'd0, 21'h0, 32'h0, 32'd120, 1'b1)), // deferred
            plain(ev(FUNC_RELEASE, 5'd31, 4'd0, 21'h0, 32'h0, 32'd121, 1'b1)),
            plain(ev(FUNC_DPAD, 5'd0, 4'd1, 21'h0, 32'h0, 32'd130, 1'b1)),
            plain(ev(FUNC_DPAD, 5'd0, 4'd15, 21'h0, 32'h0, 32'd140, 1'b1)), // early neutral
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'd150, 1'b1)),  // hold not yet met
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'd200, 1'b1)),  // deferred applied
            plain(ev(FUNC_RELEASE, 5'd20, 4'd0, 21'h0, 32'h0, 32'd300, 1'b1)),
            plain(ev(FUNC_DPAD, 5'd0, 4'd6, 21'h0, 32'h0, 32'd310, 1'b0)),
            plain(ev(FUNC_DPAD, 5'd0, 4'd8, 21'h0, 32'h0, 32'd400, 1'b1)),  // late neutral
            plain(ev(func_t'(FUNC_SPARE_LO), 5'd3, 4'd2, 21'h1F_FFFF, 32'hFFFF_FFFF,
                     32'd401, 1'b1)),
            plain(ev(func_t'(FUNC_SPARE_HI), 5'd3, 4'd2, 21'h1F_FFFF, 32'hFFFF_FFFF,
                     32'd402, 1'b1)),
            plain(ev(FUNC_SET_STATE, 5'd0, 4'd0, 21'h1F_FFFF, 32'hFFFF_FFFF, 32'd403, 1'b0)),
            known(ev(FUNC_SET_STATE, 5'd0, 4'd0, 21'h1F_FFFF, 32'hFFFF_FFFF, 32'd404, 1'b1),
                  {8'd3, 26'h3CF_7FCF, 24'hFF0FF0, 24'hFF0FF0}),
            known(ev(FUNC_SET_STATE, 5'd31, 4'd15, 21'h0, 32'h0, 32'd405, 1'b1),
                  {8'd4, 26'h0, 24'h0, 24'h0}),
            plain(ev(FUNC_SET_STATE, 5'd0, 4'd0, 21'h0A_AAAA, 32'h40C0_1080, 32'd406, 1'b1)),
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'hFFFF_FFF0, 1'b1)),
            plain(ev(FUNC_PRESS, 5'd9, 4'd0, 21'h0, 32'h0, 32'hFFFF_FFFA, 1'b1)),
            plain(ev(FUNC_TICK, 5'd0, 4'd0, 21'h0, 32'h0, 32'h0000_0002, 1'b1)), // time wraps
            plain(ev(FUNC_RELEASE, 5'd9, 4'd0, 21'h0, 32'h0, 32'h0000_0010, 1'b1))
        };
        reset_pad();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            run_event(directed_rows[r].ev, directed_rows[r].typed, directed_rows[r].rep);
        end
        wait_drained();

        // Random phases: extremes low, extremes high, then a middle setting.
        run_phase(8, 45, 16'h0000, 8'h00);
        run_phase(45, 8, 16'hFFFF, 8'hFF);
        run_phase(0, 0, 16'($urandom_range(20, 120)), 8'($urandom_range(3, 30)));

        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Give up long after the slowest correct run would have ended.
    initial begin
        #500_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
